// ----- rtl/heading_kinematics_and_jacobian_unit_defines.svh -----
// assertion macros for the heading kinematics unit
`ifndef HEADING_KINEMATICS_AND_JACOBIAN_UNIT_DEFINES_SVH
`define HEADING_KINEMATICS_AND_JACOBIAN_UNIT_DEFINES_SVH
// assert that a implies b on the same edge
`define HKJ_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define HKJ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/hkj_pkg.sv -----
// shared constants, types, trig and rounding functions for the heading kinematics unit
`timescale 1ns / 1ps
`default_nettype none
package hkj_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 16;
    localparam int QS         = ANGLE_BITS - 2;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    // horner stages of the sine series, each a product register and a divide register
    localparam int NST    = 7;
    // depth of the sine and cosine pipeline: quadrant angle, square, horner stages, rounding
    localparam int SC_LAT = 2 * NST + 3;

    // reciprocals of the series divisors 210, 156, 110, 72, 42, 20, 6
    localparam int HORNER_SH [NST] = '{40, 40, 39, 39, 38, 37, 35};
    localparam logic [32:0] HORNER_RCP [NST] = '{
        33'(((64'd1 << 40) + 64'd209) / 64'd210),
        33'(((64'd1 << 40) + 64'd155) / 64'd156),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6)
    };

    typedef enum logic [1:0] {
        OP_DYN  = 2'd0,
        OP_SJAC = 2'd1,
        OP_IJAC = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // angle remainder within a quadrant, one extra bit to hold a full quarter
    typedef logic [QS:0] t_rem;

    // quadrant angle in q2.30
    function automatic logic [31:0] quad_x(input t_rem r);
        logic [QS+32:0] p;
        begin
            p = {{32{1'b0}}, r} * {{(QS+1){1'b0}}, HALF_PI_Q30};
            p = p + ({{(QS+32){1'b0}}, 1'b1} << (QS - 1));
            quad_x = p[QS+31:QS];
        end
    endfunction

    // product half of a horner stage
    function automatic logic [31:0] horner_mul(input logic [31:0] x2, input logic [31:0] t);
        logic [63:0] m;
        begin
            m = {32'd0, x2} * {32'd0, t};
            horner_mul = m[61:30];
        end
    endfunction

    // divide half of a horner stage, exact floor by reciprocal multiplication
    function automatic logic [31:0] horner_div(input logic [31:0] n, input logic [32:0] rcp,
                                               input int sh);
        logic [64:0] m;
        logic [31:0] d;
        begin
            m = {33'd0, n} * {32'd0, rcp};
            d = 32'(m >> sh);
            horner_div = (d >= ONE_Q30) ? 32'd0 : ONE_Q30 - d;
        end
    endfunction

    // round q2.30 sine to q1.15 and clamp
    function automatic logic [15:0] sin_q15(input logic [31:0] x, input logic [31:0] t);
        logic [63:0] m;
        logic [33:0] s;
        begin
            m = {32'd0, x} * {32'd0, t};
            s = (m[63:30] + 34'd16384) >> 15;
            sin_q15 = (s > 34'd32767) ? 16'd32767 : s[15:0];
        end
    endfunction

    // signed rounding to nearest, ties away from zero
    function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
        logic [79:0] m;
        begin
            m = v[79] ? 80'(-v) : 80'(v);
            m = (m + (80'd1 << (s - 1))) >> s;
            rnd = v[79] ? -$signed(m) : $signed(m);
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/hkj_sincos.sv -----
// pipelined sine and cosine of a binary angle, q1.15 outputs
`timescale 1ns / 1ps
`default_nettype none
module hkj_sincos
    import hkj_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic        [15:0] i_angle,
    output logic signed      [15:0] o_sin,
    output logic signed      [15:0] o_cos
);
    localparam int XD = SC_LAT - 1;
    localparam int QD = SC_LAT;

    logic [ANGLE_BITS-1:0] w_p;
    logic [QS-1:0]         w_r;
    logic [1:0]            r_q [QD];
    logic [31:0]           r_x [2][XD];
    logic [31:0]           r_x2 [2][NST];
    logic [31:0]           r_x2m [2][NST-1];
    logic [31:0]           r_n [2][NST];
    logic [31:0]           r_t [2][NST+1];
    logic [15:0]           r_s [2];

    generate
        if (ANGLE_BITS == 16) begin : g_same
            assign w_p = i_angle;
        end else if (ANGLE_BITS > 16) begin : g_wide
            assign w_p = ANGLE_BITS'({i_angle, {(ANGLE_BITS-16){1'b0}}});
        end else begin : g_narrow
            assign w_p = i_angle[15 -: ANGLE_BITS];
        end
    endgenerate
    assign w_r = w_p[QS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= w_p[ANGLE_BITS-1 -: 2];
            for (int j = 1; j < QD; j++) r_q[j] <= r_q[j-1];
            r_x[0][0] <= quad_x({1'b0, w_r});
            r_x[1][0] <= quad_x(t_rem'({1'b1, {QS{1'b0}}} - {1'b0, w_r}));
            for (int c = 0; c < 2; c++) begin
                for (int j = 1; j < XD; j++) r_x[c][j] <= r_x[c][j-1];
                r_x2[c][0] <= 32'((64'(r_x[c][0]) * 64'(r_x[c][0])) >> 30);
                r_t[c][0]  <= ONE_Q30;
                for (int k = 0; k < NST; k++) begin
                    r_n[c][k]   <= horner_mul(r_x2[c][k], r_t[c][k]);
                    r_t[c][k+1] <= horner_div(r_n[c][k], HORNER_RCP[k], HORNER_SH[k]);
                end
                for (int k = 0; k < NST - 1; k++) begin
                    r_x2m[c][k]  <= r_x2[c][k];
                    r_x2[c][k+1] <= r_x2m[c][k];
                end
                r_s[c] <= sin_q15(r_x[c][XD-1], r_t[c][NST]);
            end
        end
    end

    always_comb begin
        case (r_q[QD-1])
            2'd0: begin o_sin = r_s[0]; o_cos = r_s[1]; end
            2'd1: begin o_sin = r_s[1]; o_cos = 16'(-$signed(r_s[0])); end
            2'd2: begin o_sin = 16'(-$signed(r_s[0])); o_cos = 16'(-$signed(r_s[1])); end
            default: begin o_sin = 16'(-$signed(r_s[1])); o_cos = r_s[0]; end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/heading_kinematics_and_jacobian_unit.sv -----
// heading kinematics and transposed jacobian products, deep pipeline
// an input passes the trig pipeline, stages a to e and the output register before o_valid rises
// throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage
// reset clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module heading_kinematics_and_jacobian_unit
    import hkj_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [1:0]  i_operation,
    input  wire logic signed [15:0] i_yaw_angle,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic signed [31:0] i_speed_cmd,
    input  wire logic signed [31:0] i_pitch_rate_cmd,
    input  wire logic signed [31:0] i_yaw_rate_cmd,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [31:0] i_vec_yaw,
    input  wire logic signed [31:0] i_vec_pitch,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_res_a,
    output logic signed [31:0]      o_res_b,
    output logic signed [31:0]      o_res_c,
    output logic signed [31:0]      o_res_d,
    output logic signed [31:0]      o_res_e,
    output logic                    o_saturated
);
    localparam int TD = SC_LAT;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] v, pr, yr, e0, e1, e2, e3, e4;
    } t_item;

    logic               w_adv;
    logic [TD-1:0]      r_vld;
    t_item              r_it [TD];
    logic signed [15:0] w_sy, w_cy, w_sp, w_cp;

    // stage a: trig products
    logic               r_av;
    t_item              r_ai;
    logic signed [31:0] r_cycp, r_sycp, r_cysp, r_sysp;
    logic signed [15:0] r_sp, r_cp;
    // stage b: speed and vector products
    logic               r_bv;
    t_item              r_bi;
    logic signed [79:0] r_m [8];
    // stage c: rounded terms
    logic               r_cv;
    t_item              r_ci;
    logic signed [79:0] r_t [8];
    // stage d: second products for state jacobian and carried terms for the other operations
    logic               r_dv;
    t_item              r_di;
    logic signed [79:0] r_u [8];
    // stage e: sums
    logic               r_ev;
    logic signed [79:0] r_r [5];
    // extra carried terms: speed*sy*cp for dynamics and e2*sp for input jacobian
    logic signed [79:0] r_m8, r_t8, r_sv1, r_se2;

    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    hkj_sincos u_yaw (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_yaw_angle), .o_sin(w_sy), .o_cos(w_cy)
    );
    hkj_sincos u_pitch (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(i_pitch_angle), .o_sin(w_sp), .o_cos(w_cp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_av <= 1'b0; r_bv <= 1'b0; r_cv <= 1'b0; r_dv <= 1'b0; r_ev <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld <= {r_vld[TD-2:0], i_valid};
            r_av <= r_vld[TD-1];
            r_bv <= r_av; r_cv <= r_bv; r_dv <= r_cv; r_ev <= r_dv;
            o_valid <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_it[0] <= '{i_operation, i_speed_cmd, i_pitch_rate_cmd, i_yaw_rate_cmd,
                         i_vec_x, i_vec_y, i_vec_z, i_vec_yaw, i_vec_pitch};
            for (int i = 1; i < TD; i++) r_it[i] <= r_it[i-1];
            r_ai   <= r_it[TD-1];
            r_cycp <= 32'(w_cy * w_cp);
            r_sycp <= 32'(w_sy * w_cp);
            r_cysp <= 32'(w_cy * w_sp);
            r_sysp <= 32'(w_sy * w_sp);
            r_sp   <= w_sp;
            r_cp   <= w_cp;
            // products of the speed or vector with trig terms
            r_bi <= r_ai;
            r_m[0] <= 80'(r_ai.v * r_cycp);
            r_m[1] <= 80'(r_ai.v * r_sycp);
            r_m[2] <= 80'(r_ai.v * r_cysp);
            r_m[3] <= 80'(r_ai.v * r_sysp);
            r_m[4] <= 80'(r_ai.v * r_sp);
            r_m[5] <= 80'(r_ai.v * r_cp);
            r_m[6] <= 80'(r_ai.e0 * r_cycp);
            r_m[7] <= 80'(r_ai.e1 * r_sycp);
            r_ci <= r_bi;
            r_t[0] <= rnd(r_m[0], 30);
            r_t[1] <= rnd(r_m[1], 30);
            r_t[2] <= rnd(r_m[2], 30);
            r_t[3] <= rnd(r_m[3], 30);
            r_t[4] <= rnd(r_m[4], 15);
            r_t[5] <= rnd(r_m[5], 15);
            r_t[6] <= rnd(r_m[6], 30);
            r_t[7] <= rnd(r_m[7], 30);
            // stage d products; e2*sp for input jacobian comes from the separate r_m8 path on r_sp
            r_di <= r_ci;
            r_u[0] <= 80'(r_ci.e0 * -$signed(r_t[1][32:0]));
            r_u[1] <= 80'(r_ci.e1 * $signed(r_t[0][32:0]));
            r_u[2] <= 80'(r_ci.e0 * -$signed(r_t[2][32:0]));
            r_u[3] <= 80'(r_ci.e1 * -$signed(r_t[3][32:0]));
            r_u[4] <= 80'(r_ci.e2 * -$signed(r_t[5][32:0]));
            r_u[5] <= r_t[0];
            r_u[6] <= r_t[6] + r_t[7];
            r_u[7] <= -r_t[4];
            case (t_op'(r_di.op))
                OP_DYN: begin
                    r_r[0] <= r_u[5];
                    r_r[1] <= r_sv1;
                    r_r[2] <= r_u[7];
                    r_r[3] <= 80'(r_di.yr);
                    r_r[4] <= 80'(r_di.pr);
                end
                OP_SJAC: begin
                    r_r[0] <= '0; r_r[1] <= '0; r_r[2] <= '0;
                    r_r[3] <= rnd(r_u[0], FRAC_BITS) + rnd(r_u[1], FRAC_BITS);
                    r_r[4] <= rnd(r_u[2], FRAC_BITS) + rnd(r_u[3], FRAC_BITS)
                              + rnd(r_u[4], FRAC_BITS);
                end
                OP_IJAC: begin
                    r_r[0] <= r_u[6] - r_se2;
                    r_r[1] <= 80'(r_di.e4);
                    r_r[2] <= 80'(r_di.e3);
                    r_r[3] <= '0; r_r[4] <= '0;
                end
                default: begin
                    for (int i = 0; i < 5; i++) r_r[i] <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m8  <= 80'(r_ai.e2 * r_sp);
            r_t8  <= rnd(r_m8, 15);
            r_se2 <= r_t8;
            r_sv1 <= r_t[1];
        end
    end

    logic [4:0]         w_sf;
    logic signed [31:0] w_s [5];
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (r_r[i] > 80'sd2147483647) begin
                w_s[i] = 32'sh7fffffff; w_sf[i] = 1'b1;
            end else if (r_r[i] < -80'sd2147483648) begin
                w_s[i] = 32'sh80000000; w_sf[i] = 1'b1;
            end else begin
                w_s[i] = r_r[i][31:0]; w_sf[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_res_a <= w_s[0];
            o_res_b <= w_s[1];
            o_res_c <= w_s[2];
            o_res_d <= w_s[3];
            o_res_e <= w_s[4];
            o_saturated <= |w_sf;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/hkj_checker.sv -----
// port level checks for the heading kinematics unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "heading_kinematics_and_jacobian_unit_defines.svh"
module hkj_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_ready,
    input wire logic [31:0] o_res_a,
    input wire logic        o_saturated
);
    `HKJ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_res_a))
    `HKJ_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready)
    `HKJ_ASSERT_IMP(a_stall_ready, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
    `HKJ_ASSERT_NEXT(a_sat_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_saturated))
endmodule
bind heading_kinematics_and_jacobian_unit hkj_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ready(o_ready), .o_res_a(o_res_a), .o_saturated(o_saturated)
);
`default_nettype wire

// ----- verif/heading_kinematics_and_jacobian_unit_tb.sv -----
// testbench for the heading kinematics and jacobian unit with a self-checking predictor
`timescale 1ns / 1ps
`default_nettype none
module heading_kinematics_and_jacobian_unit_tb;
    import hkj_pkg::*;

    typedef struct {
        t_op         op;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [31:0] speed;
        logic [31:0] prate;
        logic [31:0] yrate;
        logic [31:0] vx, vy, vz, vyaw, vpitch;
        bit          drain_first;
    } t_req;

    typedef struct {
        logic [31:0] a, b, c, d, e;
        logic        sat;
    } t_kin;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [1:0] i_operation = '0;
    logic signed [15:0] i_yaw_angle = '0, i_pitch_angle = '0;
    logic signed [31:0] i_speed_cmd = '0, i_pitch_rate_cmd = '0, i_yaw_rate_cmd = '0;
    logic signed [31:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic signed [31:0] i_vec_yaw = '0, i_vec_pitch = '0;
    logic o_ready, o_valid, o_saturated;
    logic signed [31:0] o_res_a, o_res_b, o_res_c, o_res_d, o_res_e;

    heading_kinematics_and_jacobian_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req pending_reqs[$];
    t_kin expected_kin[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    bit   send_burst = 0;
    bit   recv_burst = 0;
    bit   stim_done = 0;

    // quadrant sine in q1.15
    function automatic longint quarter_sine(longint unsigned r);
        longint unsigned divs[7] = '{210, 156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t, s, dq;
        x = (r * 64'd1686629713 + 64'd8192) >> 14;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 7; i++) begin
            dq = ((x2 * t) >> 30) / divs[i];
            t = (dq >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - dq;
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 32767) s = 32767;
        return longint'(s);
    endfunction

    function automatic void angle_trig(logic [15:0] ang, output longint sn, output longint cs);
        longint s0, s1;
        s0 = quarter_sine({50'd0, ang[13:0]});
        s1 = quarter_sine(64'd16384 - {50'd0, ang[13:0]});
        case (ang[15:14])
            2'd0: begin sn = s0; cs = s1; end
            2'd1: begin sn = s1; cs = -s0; end
            2'd2: begin sn = -s0; cs = -s1; end
            default: begin sn = -s1; cs = s0; end
        endcase
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin v = 64'sd2147483647; flag = 1'b1; end
        if (v < -64'sd2147483648) begin v = -64'sd2147483648; flag = 1'b1; end
        return v[31:0];
    endfunction

    function automatic t_kin kin_predict(t_req q);
        longint sy, cy, sp, cp, cycp, sycp, cysp, sysp, v, e0, e1, e2;
        longint r[5];
        logic flag;
        t_kin k;
        angle_trig(q.yaw, sy, cy);
        angle_trig(q.pitch, sp, cp);
        cycp = cy * cp; sycp = sy * cp; cysp = cy * sp; sysp = sy * sp;
        v = $signed(q.speed);
        e0 = $signed(q.vx); e1 = $signed(q.vy); e2 = $signed(q.vz);
        r = '{0, 0, 0, 0, 0};
        flag = 1'b0;
        case (q.op)
            OP_DYN: begin
                r[0] = round_shift(v * cycp, 30);
                r[1] = round_shift(v * sycp, 30);
                r[2] = -round_shift(v * sp, 15);
                r[3] = $signed(q.yrate);
                r[4] = $signed(q.prate);
            end
            OP_SJAC: begin
                r[3] = round_shift(e0 * -round_shift(v * sycp, 30), FRAC_BITS)
                     + round_shift(e1 * round_shift(v * cycp, 30), FRAC_BITS);
                r[4] = round_shift(e0 * -round_shift(v * cysp, 30), FRAC_BITS)
                     + round_shift(e1 * -round_shift(v * sysp, 30), FRAC_BITS)
                     + round_shift(e2 * -round_shift(v * cp, 15), FRAC_BITS);
            end
            OP_IJAC: begin
                r[0] = round_shift(e0 * cycp, 30) + round_shift(e1 * sycp, 30)
                     - round_shift(e2 * sp, 15);
                r[1] = $signed(q.vpitch);
                r[2] = $signed(q.vyaw);
            end
            default: ;
        endcase
        k.a = clamp32(r[0], flag); k.b = clamp32(r[1], flag); k.c = clamp32(r[2], flag);
        k.d = clamp32(r[3], flag); k.e = clamp32(r[4], flag);
        k.sat = flag;
        return k;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 200000) - 100000;
            3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req make_req(t_op op, logic [15:0] yaw, logic [15:0] pitch,
                                      logic [31:0] w);
        t_req q;
        q.op = op; q.yaw = yaw; q.pitch = pitch;
        q.speed = w; q.prate = ~w; q.yrate = w; q.vx = w; q.vy = ~w; q.vz = w;
        q.vyaw = ~w; q.vpitch = w; q.drain_first = 0;
        return q;
    endfunction

    // stimulus
    initial begin
        logic [15:0] angs[6];
        t_req q;
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'h7fff, 16'hc000, 16'h2000};
        for (int i = 0; i < 6; i++) begin
            pending_reqs.push_back(make_req(OP_DYN, angs[i], angs[5 - i], 32'h7fff_ffff));
            pending_reqs.push_back(make_req(OP_SJAC, angs[i], angs[i], 32'h8000_0000));
            pending_reqs.push_back(make_req(OP_IJAC, angs[5 - i], angs[i], 32'h8000_0000));
        end
        pending_reqs.push_back(make_req(OP_NONE, 16'hffff, 16'hffff, 32'hffff_ffff));
        pending_reqs.push_back(make_req(OP_SJAC, 16'h1234, 16'hedcb, 32'h0001_0000));
        for (int i = 0; i < 700; i++) begin
            q.op = ($urandom_range(0, 9) == 0) ? OP_NONE : t_op'($urandom_range(0, 2));
            q.yaw = $urandom; q.pitch = $urandom;
            q.speed = pick_word(); q.prate = pick_word(); q.yrate = pick_word();
            q.vx = pick_word(); q.vy = pick_word(); q.vz = pick_word();
            q.vyaw = pick_word(); q.vpitch = pick_word();
            q.drain_first = (i == 0 || i == 350);
            pending_reqs.push_back(q);
        end
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 5) i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_kin.push_back(kin_predict('{t_op'(i_operation), i_yaw_angle,
                    i_pitch_angle, i_speed_cmd, i_pitch_rate_cmd, i_yaw_rate_cmd, i_vec_x,
                    i_vec_y, i_vec_z, i_vec_yaw, i_vec_pitch, 1'b0}));
                if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 11);
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() != 0 && !(pending_reqs[0].drain_first
                             && (expected_kin.size() != 0 || (i_valid && !o_ready)))) begin
                    t_req q;
                    q = pending_reqs.pop_front();
                    i_operation <= q.op;
                    i_yaw_angle <= q.yaw; i_pitch_angle <= q.pitch;
                    i_speed_cmd <= q.speed; i_pitch_rate_cmd <= q.prate;
                    i_yaw_rate_cmd <= q.yrate;
                    i_vec_x <= q.vx; i_vec_y <= q.vy; i_vec_z <= q.vz;
                    i_vec_yaw <= q.vyaw; i_vec_pitch <= q.vpitch;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        int nxt;
        t_kin k;
        nxt = 0;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_kin.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
            end else begin
                k = expected_kin.pop_front();
                if ({o_res_a, o_res_b, o_res_c, o_res_d, o_res_e, o_saturated}
                    !== {k.a, k.b, k.c, k.d, k.e, k.sat}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                                 k.a, k.b, k.c, k.d, k.e, k.sat, o_res_a, o_res_b, o_res_c,
                                 o_res_d, o_res_e, o_saturated);
                end
            end
            if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
            nxt = recv_burst ? 0 : $urandom_range(0, 11);
        end else if (recv_stall > 0) begin
            nxt = recv_stall - 1;
        end
        recv_stall <= nxt;
        i_ready <= i_rst_n && (nxt == 0);
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_kin.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_kin.size() == 0)
            $display("heading_kinematics_and_jacobian_unit_tb passed");
        else
            $display("heading_kinematics_and_jacobian_unit_tb failed");
        $finish;
    end

    initial begin
        wait (cycles >= 300000);
        $display("heading_kinematics_and_jacobian_unit_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
